// ===== rtl/bounded_stack_with_sort_defines.svh =====
// assertion macros for the bounded stack with sort
// used by rtl files that carry concurrent checks; needs i_clk and i_rst_n in scope
`ifndef BOUNDED_STACK_WITH_SORT_DEFINES_SVH
`define BOUNDED_STACK_WITH_SORT_DEFINES_SVH

// same-cycle implication, held off during reset
`define BSWS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define BSWS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bsws_pkg.sv =====
// shared types and constants for the bounded stack with sort
// no dependencies
package bsws_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int WORD_W        = 32;
    localparam int CNT_OUT_W     = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    // command codes, the fourth code is a no-op
    typedef enum logic [1:0] {
        CMD_PUSH = 2'd0,
        CMD_POP  = 2'd1,
        CMD_SORT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SORT,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic [1:0] cmd;
        t_word      push_value;
    } t_in_word;

    typedef struct packed {
        t_word                popped_value;
        t_word                top_value;
        logic                 top_valid;
        logic [CNT_OUT_W-1:0] entry_count;
        logic [CNT_OUT_W-1:0] odd_count;
        logic [1:0]           error_code;
    } t_out_word;

    // control broadcast to every cell
    typedef struct packed {
        logic shift_dn;
        logic shift_up;
        logic sort_step;
        logic phase;
    } t_cell_ctl;

endpackage

// ===== rtl/bsws_cell.sv =====
// one stack cell: holds one entry, shifts with push and pop, compare-swaps for sort
// depends on bsws_pkg
module bsws_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 5
) (
    input  logic                i_clk,
    input  bsws_pkg::t_cell_ctl i_ctl,
    input  logic [CNT_W-1:0]    i_count,
    input  bsws_pkg::t_word     i_upper,
    input  bsws_pkg::t_word     i_lower,
    output bsws_pkg::t_word     o_val
);
    import bsws_pkg::*;

    localparam logic [CNT_W:0] SELF_POS  = (CNT_W+1)'(IDX);
    localparam logic [CNT_W:0] LOWER_POS = (CNT_W+1)'(IDX + 1);
    localparam logic           PARITY    = 1'(IDX % 2);
    localparam logic           HAS_UPPER = (IDX > 0);

    t_word r_val;
    t_word n_val;
    logic  w_self_occ;
    logic  w_lower_occ;
    logic  w_leader;
    logic  w_follower;

    // occupancy from the fill count, pair role from the sort phase
    assign w_self_occ  = SELF_POS < {1'b0, i_count};
    assign w_lower_occ = LOWER_POS < {1'b0, i_count};
    assign w_leader    = (i_ctl.phase == PARITY);
    assign w_follower  = HAS_UPPER && (i_ctl.phase != PARITY);

    // leader keeps the smaller of its pair, follower the larger
    always_comb begin
        n_val = r_val;
        if (i_ctl.shift_dn) begin
            n_val = i_upper;
        end else if (i_ctl.shift_up) begin
            n_val = i_lower;
        end else if (i_ctl.sort_step) begin
            if (w_leader && w_lower_occ && (i_lower < r_val)) begin
                n_val = i_lower;
            end else if (w_follower && w_self_occ && (r_val < i_upper)) begin
                n_val = i_upper;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

// ===== rtl/bounded_stack_with_sort.sv =====
// top level of the bounded stack with sort: control, counters and result register
// depends on bsws_pkg, bsws_cell and bounded_stack_with_sort_defines.svh
//
// A LIFO of DEPTH signed 32-bit entries kept in a row of cells, the top entry in
// the first cell. Push and pop shift the whole row by one place, so a new word is
// accepted every cycle while no sort runs and the result register can be emptied.
// Sort runs an odd-even transposition over the row: one compare-swap phase per
// cycle, as many phases as there are entries, then a step that loads the result.
// A sort of n entries (n of two or more) holds off input until its result is
// loaded. Every word gives exactly one result word.
module bounded_stack_with_sort #(
    parameter int DEPTH = bsws_pkg::DEPTH_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  bsws_pkg::t_in_word i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output bsws_pkg::t_out_word o_out_data
);
    import bsws_pkg::*;

    `include "bounded_stack_with_sort_defines.svh"

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CNT_W-1:0] r_odd;
    logic [CNT_W-1:0] n_odd;
    logic [CNT_W-1:0] r_pass;
    logic             r_phase;
    logic             r_out_valid;
    t_out_word        r_out;
    t_out_word        n_out;
    logic             w_load_out;
    logic             w_in_fire;
    logic             w_sort_start;
    logic             w_push_ok;
    t_cell_ctl        w_ctl;
    t_word            w_up  [DEPTH];
    t_word            w_val [DEPTH+1];

    // row of cells, the extra slot past the bottom reads as zero
    assign w_val[DEPTH] = '0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_up[g] = i_in_data.push_value;
        end else begin : g_body
            assign w_up[g] = w_val[g-1];
        end
        bsws_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_upper (w_up[g]),
            .i_lower (w_val[g+1]),
            .o_val   (w_val[g])
        );
    end

    // input handshake
    assign o_in_ready   = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_sort_start = w_in_fire && (i_in_data.cmd == CMD_SORT) && (r_count > CNT_ONE);
    assign w_push_ok    = w_in_fire && (i_in_data.cmd == CMD_PUSH) && (r_count != CNT_FULL);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_sort_start) begin
                    n_state = ST_SORT;
                end
            end
            ST_SORT: begin
                if (r_pass == CNT_ONE) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // cell control, counters and result word
    always_comb begin
        w_ctl              = '0;
        w_ctl.phase        = r_phase;
        n_count            = r_count;
        n_odd              = r_odd;
        w_load_out         = 1'b0;
        n_out              = '0;
        n_out.top_value    = (r_count != '0) ? w_val[0] : '0;
        n_out.top_valid    = (r_count != '0);
        n_out.error_code   = ERR_NONE;
        case (r_state)
            ST_IDLE: begin
                if (w_in_fire && !w_sort_start) begin
                    w_load_out = 1'b1;
                    case (i_in_data.cmd)
                        CMD_PUSH: begin
                            if (r_count == CNT_FULL) begin
                                n_out.error_code = ERR_FULL;
                            end else begin
                                w_ctl.shift_dn  = 1'b1;
                                n_count         = r_count + CNT_ONE;
                                n_odd           = r_odd + CNT_W'(i_in_data.push_value[0]);
                                n_out.top_value = i_in_data.push_value;
                                n_out.top_valid = 1'b1;
                            end
                        end
                        CMD_POP: begin
                            if (r_count == '0) begin
                                n_out.error_code = ERR_EMPTY;
                            end else begin
                                w_ctl.shift_up     = 1'b1;
                                n_count            = r_count - CNT_ONE;
                                n_odd              = r_odd - CNT_W'(w_val[0][0]);
                                n_out.popped_value = w_val[0];
                                n_out.top_value    = (r_count > CNT_ONE) ? w_val[1] : '0;
                                n_out.top_valid    = (r_count > CNT_ONE);
                            end
                        end
                        default: begin
                            // short sort or unused code: report state as it is
                        end
                    endcase
                    n_out.entry_count = CNT_OUT_W'(n_count);
                    n_out.odd_count   = CNT_OUT_W'(n_odd);
                end
            end
            ST_SORT: begin
                w_ctl.sort_step = 1'b1;
            end
            ST_DONE: begin
                w_load_out        = 1'b1;
                n_out.entry_count = CNT_OUT_W'(r_count);
                n_out.odd_count   = CNT_OUT_W'(r_odd);
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_odd       <= '0;
            r_pass      <= '0;
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_odd   <= n_odd;
            if (w_sort_start) begin
                r_pass  <= r_count;
                r_phase <= 1'b0;
            end else if (r_state == ST_SORT) begin
                r_pass  <= r_pass - CNT_ONE;
                r_phase <= !r_phase;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `BSWS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CNT_FULL, "fill count past depth")
    `BSWS_ASSERT_NOW(a_odd_bound, 1'b1, r_odd <= r_count, "odd count above fill count")
    `BSWS_ASSERT_NOW(a_busy_stall, r_state != ST_IDLE, !o_in_ready, "input taken while sorting")
    `BSWS_ASSERT_NEXT(a_done_out, r_state == ST_DONE, o_out_valid, "sort ended without result")
    `BSWS_ASSERT_NEXT(a_push_count, w_push_ok, r_count == $past(r_count) + CNT_ONE, "push lost")

endmodule
